### hdl/csfe_pkg.sv
// Package for the SLIP frame encoder: job type, SLIP codes and the CRC step.
package csfe_pkg;

  // SLIP codes
  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Header layout: type, length, address, count, offset, requested bytes
  localparam int HdrBits     = 136;
  localparam int HdrBytes    = HdrBits / 8;
  localparam int IdxW        = $clog2(HdrBytes);
  localparam logic [IdxW-1:0] LastIdxShort = IdxW'(2);
  localparam logic [IdxW-1:0] LastIdxLong  = IdxW'(HdrBytes - 1);

  // Job queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // One job: a header or one in-frame payload byte (held in byte 0 of body)
  typedef struct packed {
    logic               is_hdr;
    logic               storage;
    logic               close;
    logic [HdrBits-1:0] body;
  } job_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_BYTE,
    ST_ESC,
    ST_CLOSE
  } back_state_t;

  // Source of the byte in ST_BYTE
  typedef enum logic [1:0] {
    SRC_FIELD,
    SRC_CRC_HI,
    SRC_CRC_LO
  } byte_src_t;

  // Advance the CRC by one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/csfe_front.sv
// Front end: accepts requests, tracks the open frame and queues jobs.
module csfe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_storage_mode,
  input  logic                 acc,
  input  logic                 command,
  input  logic [7:0]           pkt_kind,
  input  logic [15:0]          payload_length,
  input  logic [31:0]          block_address,
  input  logic [15:0]          blk_count,
  input  logic [31:0]          byte_offset,
  input  logic [31:0]          requested_bytes,
  input  logic [7:0]           data_byte,
  output logic                 q_push,
  output csfe_pkg::job_t       q_job
);

  logic        storage_r;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] left_r, left_nxt;

  // Hold the storage mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      storage_r <= 1'b0;
    end else if (cfg_we) begin
      storage_r <= cfg_storage_mode;
    end
  end

  // Classify the request and build the job
  always_comb begin
    in_frame_nxt = in_frame_r;
    left_nxt     = left_r;
    q_push       = 1'b0;
    q_job.is_hdr  = ~command;
    q_job.storage = storage_r;
    q_job.close   = 1'b0;
    q_job.body    = {requested_bytes, byte_offset, blk_count, block_address,
                     payload_length, pkt_kind};
    if (acc) begin
      if (!command) begin
        q_push       = 1'b1;
        q_job.close  = (payload_length == 16'd0);
        in_frame_nxt = (payload_length != 16'd0);
        left_nxt     = payload_length;
      end else if (in_frame_r) begin
        q_push      = 1'b1;
        q_job.body  = {{(csfe_pkg::HdrBits-8){1'b0}}, data_byte};
        q_job.close = (left_r == 16'd1);
        left_nxt    = left_r - 16'd1;
        if (left_r == 16'd1) begin
          in_frame_nxt = 1'b0;
        end
      end
    end
  end

  // Advance the frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      left_r     <= 16'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      left_r     <= left_nxt;
    end
  end

endmodule

### hdl/csfe_queue.sv
// Short job queue between front and back ends.
module csfe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csfe_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output csfe_pkg::job_t rd_job
);

  csfe_pkg::job_t                mem_r [csfe_pkg::QDepth];
  logic [csfe_pkg::QPtrW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [csfe_pkg::QPtrW:0]      count_r;

  assign full   = (count_r == (csfe_pkg::QPtrW+1)'(csfe_pkg::QDepth));
  assign empty  = (count_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hdl/csfe_back.sv
// Back end: serializes jobs into escaped SLIP bytes with the CRC trailer.
module csfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  csfe_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_last_in_run,
  output logic           out_frame_end
);

  csfe_pkg::back_state_t        state_r, state_nxt;
  csfe_pkg::byte_src_t          src_r, src_nxt;
  csfe_pkg::job_t               job_r;
  logic [csfe_pkg::IdxW-1:0]    idx_r, idx_nxt;
  logic [15:0]                  crc_r, crc_nxt;
  logic [7:0]                   esc_r, esc_nxt;
  logic                         load;

  logic                         out_valid_r;
  logic [7:0]                   out_byte_r;
  logic                         out_last_r, out_end_r;

  logic                         adv;
  logic                         emit;
  logic [7:0]                   emit_byte;
  logic                         emit_last, emit_end;
  logic [7:0]                   cur_byte;
  logic [csfe_pkg::IdxW-1:0]    last_idx;
  logic                         field_done;

  assign adv       = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_in_run = out_last_r;
  assign out_frame_end   = out_end_r;

  assign last_idx = !job_r.is_hdr ? '0 :
                    (job_r.storage ? csfe_pkg::LastIdxLong : csfe_pkg::LastIdxShort);

  // Select the raw byte for the current step
  always_comb begin
    case (src_r)
      csfe_pkg::SRC_CRC_HI: cur_byte = crc_r[15:8];
      csfe_pkg::SRC_CRC_LO: cur_byte = crc_r[7:0];
      default:              cur_byte = job_r.body[{idx_r, 3'b000} +: 8];
    endcase
  end

  // Sequence the job bytes
  always_comb begin
    state_nxt  = state_r;
    src_nxt    = src_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    esc_nxt    = esc_r;
    load       = 1'b0;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_byte  = csfe_pkg::SlipEnd;
    emit_last  = 1'b0;
    emit_end   = 1'b0;
    field_done = 1'b0;
    unique case (state_r)
      csfe_pkg::ST_IDLE: begin
        if (!q_empty) begin
          load    = 1'b1;
          q_pop   = 1'b1;
          idx_nxt = '0;
          src_nxt = csfe_pkg::SRC_FIELD;
          if (q_job.is_hdr) begin
            crc_nxt   = csfe_pkg::CrcInit;
            state_nxt = csfe_pkg::ST_OPEN;
          end else begin
            state_nxt = csfe_pkg::ST_BYTE;
          end
        end
      end
      csfe_pkg::ST_OPEN: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = csfe_pkg::SlipEnd;
          state_nxt = csfe_pkg::ST_BYTE;
        end
      end
      csfe_pkg::ST_BYTE: begin
        if (adv) begin
          emit = 1'b1;
          if (src_r == csfe_pkg::SRC_FIELD) begin
            crc_nxt = csfe_pkg::crc_feed(crc_r, cur_byte);
          end
          if (cur_byte == csfe_pkg::SlipEnd || cur_byte == csfe_pkg::SlipEsc) begin
            emit_byte = csfe_pkg::SlipEsc;
            esc_nxt   = (cur_byte == csfe_pkg::SlipEnd) ? csfe_pkg::SlipEscEnd
                                                        : csfe_pkg::SlipEscEsc;
            state_nxt = csfe_pkg::ST_ESC;
          end else begin
            emit_byte  = cur_byte;
            field_done = 1'b1;
          end
        end
      end
      csfe_pkg::ST_ESC: begin
        if (adv) begin
          emit       = 1'b1;
          emit_byte  = esc_r;
          field_done = 1'b1;
        end
      end
      csfe_pkg::ST_CLOSE: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = csfe_pkg::SlipEnd;
          emit_last = 1'b1;
          emit_end  = 1'b1;
          state_nxt = csfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = csfe_pkg::ST_IDLE;
    endcase

    // Step to the next byte once the current one is fully sent
    if (field_done) begin
      unique case (src_r)
        csfe_pkg::SRC_CRC_HI: begin
          src_nxt   = csfe_pkg::SRC_CRC_LO;
          state_nxt = csfe_pkg::ST_BYTE;
        end
        csfe_pkg::SRC_CRC_LO: begin
          state_nxt = csfe_pkg::ST_CLOSE;
        end
        default: begin
          if (idx_r != last_idx) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = csfe_pkg::ST_BYTE;
          end else if (job_r.close) begin
            src_nxt   = csfe_pkg::SRC_CRC_HI;
            state_nxt = csfe_pkg::ST_BYTE;
          end else begin
            emit_last = 1'b1;
            state_nxt = csfe_pkg::ST_IDLE;
          end
        end
      endcase
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csfe_pkg::ST_IDLE;
      src_r   <= csfe_pkg::SRC_FIELD;
      idx_r   <= '0;
      crc_r   <= csfe_pkg::CrcInit;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // Capture the job and pending escape code
  always_ff @(posedge clk) begin
    esc_r <= esc_nxt;
    if (load) begin
      job_r <= q_job;
    end
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_end_r  <= emit_end;
    end
  end

  // A closing END is always the end of its run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_last_r && out_byte_r == csfe_pkg::SlipEnd))
    else $error("closing END without last_in_run");

  // While the second half of an escape waits, the escape byte is shown
  a_esc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csfe_pkg::ST_ESC) |-> (out_valid_r && out_byte_r == csfe_pkg::SlipEsc))
    else $error("escape pending without escape byte at the output");

  // The closing END only follows the low CRC byte
  a_close_after_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csfe_pkg::ST_CLOSE) |-> (src_r == csfe_pkg::SRC_CRC_LO))
    else $error("closing END reached without CRC");

endmodule

### hdl/crc_slip_frame_encoder.sv
// Top level of the SLIP frame encoder with CRC-16/CCITT-FALSE trailer.
//
// Input channel: push a request while full is low. A header request
// (in_command 0) opens a frame; a payload request (in_command 1) adds one
// data byte to the open frame and is dropped when no frame is open.
// Result channel: while out_empty is low the next encoded byte is shown;
// pop takes it. out_last_in_run marks the last byte caused by one request,
// out_frame_end the closing END.
// Configuration: cfg_we writes cfg_storage_mode; it is sampled per header.
// Requests go through a four-entry job queue; the back end emits one byte
// per cycle from the output register while the receiver pops, and none
// while it loads a job. An escaped byte goes out as ESC and its code; a
// header is an opening END and three field bytes (seventeen in storage
// mode), and a closing run adds the two CRC bytes and a closing END.
// Reset clears the queue, the frame state and the storage mode. When the
// receiver stalls, the output register holds and the queue fills; full
// then rises and holds off further requests.
module crc_slip_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_storage_mode,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [7:0]  in_pkt_kind,
  input  logic [15:0] in_payload_length,
  input  logic [31:0] in_block_address,
  input  logic [15:0] in_blk_count,
  input  logic [31:0] in_byte_offset,
  input  logic [31:0] in_requested_bytes,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_last_in_run,
  output logic        out_frame_end
);

  logic           acc;
  logic           q_push, q_pop, q_empty;
  csfe_pkg::job_t q_wr_job, q_rd_job;

  assign acc = in_push && !in_full;

  csfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_storage_mode (cfg_storage_mode),
    .acc              (acc),
    .command          (in_command),
    .pkt_kind         (in_pkt_kind),
    .payload_length   (in_payload_length),
    .block_address    (in_block_address),
    .blk_count        (in_blk_count),
    .byte_offset      (in_byte_offset),
    .requested_bytes  (in_requested_bytes),
    .data_byte        (in_data_byte),
    .q_push           (q_push),
    .q_job            (q_wr_job)
  );

  csfe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (in_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (q_rd_job)
  );

  csfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (q_rd_job),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run),
    .out_frame_end   (out_frame_end)
  );

endmodule
